[hdl/key_matrix_hid_report_builder_core_macros.svh]
// Assertion macros for the key matrix report builder
`ifndef KEY_MATRIX_HID_REPORT_BUILDER_CORE_MACROS_SVH
`define KEY_MATRIX_HID_REPORT_BUILDER_CORE_MACROS_SVH
`define KMHRB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define KMHRB_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[hdl/kmhrb_pkg.sv]
// Shared types, constants and key table for the key matrix report builder
`default_nettype none
package kmhrb_pkg;
  localparam int unsigned TableRows = 17;
  localparam int unsigned Cols = 8;
  localparam logic [14:0] FrameWrap = 15'd32767;
  localparam logic [12:0] DeltaClamp = 13'd5000;
  localparam logic [12:0] IdleReset = 13'd500;
  localparam logic [7:0] ShiftMod = 8'h40;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindChar = 2'd1,
    KindMod  = 2'd2,
    KindAux  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] modm;
    kind_e      kind;
  } entry_t;

  typedef struct packed {
    logic valid;
    entry_t ent;
  } key_evt_t;

  function automatic entry_t ch(input logic [7:0] k);
    ch = '{code: k, modm: 8'h00, kind: KindChar};
  endfunction
  function automatic entry_t sh(input logic [7:0] k);
    sh = '{code: k, modm: ShiftMod, kind: KindChar};
  endfunction
  function automatic entry_t md(input logic [7:0] k, input logic [7:0] m);
    md = '{code: k, modm: m, kind: KindMod};
  endfunction
  function automatic entry_t ax(input logic [7:0] k);
    ax = '{code: k, modm: 8'h00, kind: KindAux};
  endfunction
  function automatic entry_t nk();
    nk = '{code: 8'h00, modm: 8'h00, kind: KindNone};
  endfunction

  function automatic entry_t key_lookup(input logic [4:0] r, input logic [2:0] c);
    entry_t e;
    e = nk();
    unique case ({r, c})
      {5'd0, 3'd0}: e = ch(8'h3e); {5'd0, 3'd1}: e = ch(8'h3f);
      {5'd0, 3'd2}: e = ch(8'h40); {5'd0, 3'd3}: e = ch(8'h41);
      {5'd0, 3'd4}: e = ch(8'h42); {5'd0, 3'd5}: e = ch(8'h43);
      {5'd0, 3'd6}: e = ch(8'h44); {5'd0, 3'd7}: e = ch(8'h45);
      {5'd1, 3'd0}: e = ch(8'h21); {5'd1, 3'd1}: e = ch(8'h1e);
      {5'd1, 3'd2}: e = ch(8'h1f); {5'd1, 3'd3}: e = ch(8'h20);
      {5'd1, 3'd4}: e = ch(8'h22); {5'd1, 3'd5}: e = ch(8'h23);
      {5'd1, 3'd6}: e = ch(8'h24); {5'd1, 3'd7}: e = ch(8'h25);
      {5'd2, 3'd0}: e = sh(8'h18); {5'd2, 3'd1}: e = sh(8'h15);
      {5'd2, 3'd2}: e = sh(8'h17); {5'd2, 3'd3}: e = sh(8'h1c);
      {5'd2, 3'd4}: e = sh(8'h0c); {5'd2, 3'd5}: e = sh(8'h14);
      {5'd2, 3'd6}: e = sh(8'h1a); {5'd2, 3'd7}: e = sh(8'h08);
      {5'd3, 3'd0}: e = ch(8'h35); {5'd3, 3'd1}: e = ch(8'h39);
      {5'd3, 3'd2}: e = ch(8'h2b); {5'd3, 3'd3}: e = ch(8'h29);
      {5'd3, 3'd4}: e = ch(8'h3a); {5'd3, 3'd5}: e = ch(8'h3b);
      {5'd3, 3'd6}: e = ch(8'h3c); {5'd3, 3'd7}: e = ch(8'h3d);
      {5'd4, 3'd0}: e = ch(8'h26); {5'd4, 3'd1}: e = ch(8'h27);
      {5'd4, 3'd2}: e = ch(8'h2d); {5'd4, 3'd3}: e = ch(8'h2e);
      {5'd4, 3'd4}: e = ax(8'd7);  {5'd4, 3'd5}: e = ax(8'd6);
      {5'd4, 3'd6}: e = ax(8'd5);  {5'd4, 3'd7}: e = ax(8'd1);
      {5'd5, 3'd1}: e = ax(8'd2);
      {5'd5, 3'd2}: e = ch(8'h49); {5'd5, 3'd3}: e = ch(8'h4a);
      {5'd5, 3'd4}: e = ch(8'h4b); {5'd5, 3'd5}: e = ch(8'h4e);
      {5'd5, 3'd6}: e = ch(8'h4d); {5'd5, 3'd7}: e = ch(8'h4c);
      {5'd6, 3'd0}: e = sh(8'h16); {5'd6, 3'd1}: e = sh(8'h07);
      {5'd6, 3'd2}: e = ch(8'h31); {5'd6, 3'd3}: e = ax(8'd4);
      {5'd6, 3'd4}: e = ax(8'd3);  {5'd6, 3'd5}: e = sh(8'h12);
      {5'd6, 3'd6}: e = sh(8'h13); {5'd6, 3'd7}: e = sh(8'h04);
      {5'd7, 3'd0}: e = ch(8'h14); {5'd7, 3'd1}: e = ch(8'h15);
      {5'd7, 3'd2}: e = ch(8'h17); {5'd7, 3'd3}: e = sh(8'h09);
      {5'd7, 3'd4}: e = sh(8'h0a); {5'd7, 3'd5}: e = sh(8'h0b);
      {5'd7, 3'd6}: e = ch(8'h1a); {5'd7, 3'd7}: e = ch(8'h08);
      {5'd8, 3'd0}: e = ch(8'h16); {5'd8, 3'd1}: e = sh(8'h1b);
      {5'd8, 3'd2}: e = sh(8'h0e); {5'd8, 3'd3}: e = sh(8'h1d);
      {5'd8, 3'd4}: e = ch(8'h04); {5'd8, 3'd5}: e = ch(8'h07);
      {5'd8, 3'd6}: e = ch(8'h09); {5'd8, 3'd7}: e = sh(8'h0f);
      {5'd9, 3'd0}: e = ch(8'h2a); {5'd9, 3'd1}: e = ch(8'h30);
      {5'd9, 3'd2}: e = ch(8'h0c); {5'd9, 3'd3}: e = ch(8'h18);
      {5'd9, 3'd4}: e = ch(8'h1c); {5'd9, 3'd5}: e = ch(8'h12);
      {5'd9, 3'd6}: e = ch(8'h2f); {5'd9, 3'd7}: e = ch(8'h13);
      {5'd10, 3'd0}: e = ch(8'h0e); {5'd10, 3'd1}: e = ch(8'h0b);
      {5'd10, 3'd2}: e = ch(8'h34); {5'd10, 3'd3}: e = ch(8'h33);
      {5'd10, 3'd4}: e = ch(8'h0f); {5'd10, 3'd5}: e = ch(8'h28);
      {5'd10, 3'd6}: e = ch(8'h0d); {5'd10, 3'd7}: e = ch(8'h0a);
      {5'd11, 3'd0}: e = ch(8'h19); {5'd11, 3'd1}: e = ch(8'h1b);
      {5'd11, 3'd2}: e = sh(8'h05); {5'd11, 3'd3}: e = ch(8'h06);
      {5'd11, 3'd4}: e = sh(8'h19); {5'd11, 3'd5}: e = ch(8'h1d);
      {5'd11, 3'd6}: e = sh(8'h06); {5'd11, 3'd7}: e = sh(8'h11);
      {5'd12, 3'd0}: e = md(8'he6, 8'h40); {5'd12, 3'd1}: e = md(8'he3, 8'h08);
      {5'd12, 3'd2}: e = md(8'he1, 8'h02); {5'd12, 3'd3}: e = md(8'he2, 8'h04);
      {5'd12, 3'd4}: e = sh(8'h0d);        {5'd12, 3'd5}: e = md(8'he7, 8'h80);
      {5'd12, 3'd6}: e = ch(8'h2c);        {5'd12, 3'd7}: e = md(8'he0, 8'h01);
      {5'd13, 3'd0}: e = ch(8'h38); {5'd13, 3'd1}: e = ch(8'h37);
      {5'd13, 3'd2}: e = ch(8'h36); {5'd13, 3'd3}: e = ch(8'h10);
      {5'd13, 3'd4}: e = ch(8'h11); {5'd13, 3'd5}: e = ch(8'h05);
      {5'd13, 3'd7}: e = md(8'he5, 8'h20);
      {5'd14, 3'd0}: e = ch(8'h5a); {5'd14, 3'd1}: e = ch(8'h5d);
      {5'd14, 3'd2}: e = ch(8'h60); {5'd14, 3'd3}: e = ch(8'h54);
      {5'd14, 3'd4}: e = ch(8'h53); {5'd14, 3'd5}: e = ch(8'h5f);
      {5'd14, 3'd6}: e = ch(8'h5c); {5'd14, 3'd7}: e = ch(8'h59);
      {5'd15, 3'd0}: e = ch(8'h56); {5'd15, 3'd1}: e = ch(8'h57);
      {5'd15, 3'd2}: e = ch(8'h58); {5'd15, 3'd3}: e = ch(8'h63);
      {5'd15, 3'd4}: e = ch(8'h5b); {5'd15, 3'd5}: e = ch(8'h5e);
      {5'd15, 3'd6}: e = ch(8'h61); {5'd15, 3'd7}: e = ch(8'h55);
      {5'd16, 3'd0}: e = ch(8'h52); {5'd16, 3'd1}: e = ch(8'h50);
      {5'd16, 3'd2}: e = ch(8'h51); {5'd16, 3'd3}: e = ch(8'h4f);
      {5'd16, 3'd4}: e = md(8'he4, 8'h10); {5'd16, 3'd5}: e = ch(8'h62);
      {5'd16, 3'd6}: e = ch(8'h65);
      default: e = nk();
    endcase
    key_lookup = e;
  endfunction
endpackage
`default_nettype wire

[hdl/kmhrb_col_scan.sv]
// Column serialiser: shifts a row sample out one column bit per cycle
`default_nettype none
module kmhrb_col_scan (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [4:0]          row_i,
  input  wire logic [7:0]          columns_i,
  output logic                     busy_o,
  output kmhrb_pkg::key_evt_t      evt_o
);
  logic [7:0] col_q, col_d;
  logic [2:0] idx_q, idx_d;
  logic [4:0] row_q, row_d;
  logic       busy_q, busy_d;

  always_comb begin
    col_d = col_q; idx_d = idx_q; row_d = row_q; busy_d = busy_q;
    if (start_i) begin
      col_d = columns_i; idx_d = '0; row_d = row_i; busy_d = 1'b1;
    end else if (busy_q) begin
      col_d = {1'b0, col_q[7:1]};
      idx_d = idx_q + 3'd1;
      if (idx_q == 3'd7) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; idx_q <= '0;
    end else begin
      busy_q <= busy_d; idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d; row_q <= row_d;
  end

  assign busy_o = busy_q;
  assign evt_o.valid = busy_q & col_q[0];
  assign evt_o.ent = kmhrb_pkg::key_lookup(row_q, idx_q);
endmodule
`default_nettype wire

[hdl/kmhrb_collect.sv]
// Scan collector: press slots, key bytes, modifier byte and auxiliary bytes
`default_nettype none
module kmhrb_collect #(
  parameter int unsigned PRESS_LIMIT = 8,
  parameter int unsigned REPORT_KEYS = 6,
  parameter int unsigned AUX_KEYS    = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  kmhrb_pkg::key_evt_t  evt_i,
  input  wire logic            clear_i,
  output logic [7:0]           mod_o,
  output logic [47:0]          keys_o,
  output logic [31:0]          aux_o
);
  localparam int unsigned AuxN = (AUX_KEYS < 4) ? AUX_KEYS : 4;
  logic [4:0]  press_q;
  logic [2:0]  ccnt_q;
  logic [2:0]  acnt_q;
  logic [7:0]  mod_q;
  logic [47:0] keys_q;
  logic [31:0] aux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0; ccnt_q <= '0; acnt_q <= '0;
      mod_q <= '0; keys_q <= '0; aux_q <= '0;
    end else if (clear_i) begin
      press_q <= '0; ccnt_q <= '0; acnt_q <= '0;
      mod_q <= '0; keys_q <= '0; aux_q <= '0;
    end else if (evt_i.valid && press_q < 5'(PRESS_LIMIT)) begin
      press_q <= press_q + 5'd1;
      case (evt_i.ent.kind)
        kmhrb_pkg::KindChar: begin
          if (ccnt_q < 3'(REPORT_KEYS)) begin
            keys_q[ccnt_q*8 +: 8] <= evt_i.ent.code;
            mod_q  <= mod_q | evt_i.ent.modm;
            ccnt_q <= ccnt_q + 3'd1;
          end
        end
        kmhrb_pkg::KindMod: mod_q <= mod_q | evt_i.ent.modm;
        kmhrb_pkg::KindAux: begin
          if (acnt_q < 3'(AuxN)) begin
            aux_q[acnt_q[1:0]*8 +: 8] <= evt_i.ent.code;
            acnt_q <= acnt_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign mod_o = mod_q;
  assign keys_o = keys_q;
  assign aux_o = aux_q;
endmodule
`default_nettype wire

[hdl/key_matrix_hid_report_builder_core.sv]
// Top level of the key matrix report builder
// A row sample holds the input while the column serialiser is started, walks
// the column bits one per cycle through the key table and the collector, and
// returns to idle. A row outside the table is dropped without a scan. An
// end-of-scan word passes through the frame delta stage, then compare and
// send. Its result word is registered and held in an output register until
// taken. While that register is full, the next end-of-scan word waits in the
// send stage.
`default_nettype none
module key_matrix_hid_report_builder_core #(
  parameter int unsigned ROWS        = 17,
  parameter int unsigned PRESS_LIMIT = 8,
  parameter int unsigned REPORT_KEYS = 6,
  parameter int unsigned AUX_KEYS    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [4:0]  row_i,
  input  wire logic [7:0]  columns_i,
  input  wire logic [14:0] frame_count_i,
  input  wire logic        key_port_busy_i,
  input  wire logic        aux_port_busy_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             key_send_o,
  output logic [7:0]       modifier_byte_o,
  output logic [47:0]      key_bytes_o,
  output logic             aux_send_o,
  output logic [31:0]      aux_bytes_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  `include "key_matrix_hid_report_builder_core_macros.svh"

  typedef enum logic [1:0] {StIdle, StRow, StDelta, StSend} state_e;

  state_e      state_q;
  logic [12:0] idle_q;
  logic [55:0] last_key_q;
  logic [31:0] last_aux_q;
  logic [16:0] lsf_q;
  logic [16:0] delta_q;
  logic [14:0] now_q;
  logic        kbusy_q, abusy_q;
  logic        ov_q;
  logic        ks_q, as_q;
  logic [7:0]  mb_q;
  logic [47:0] kb_q;
  logic [31:0] ab_q;

  logic                  scan_start, scan_busy, clear;
  kmhrb_pkg::key_evt_t   evt;
  logic [7:0]            mod;
  logic [47:0]           keys;
  logic [31:0]           aux;
  logic                  acc;
  logic                  load;

  assign in_ready_o = (state_q == StIdle);
  assign acc = in_valid_i && in_ready_o;
  assign scan_start = acc && !opcode_i && ({1'b0, row_i} < 6'(ROWS))
                      && (row_i < 5'(kmhrb_pkg::TableRows));
  assign load = (state_q == StSend) && (!ov_q || out_ready_i);
  assign clear = load;

  kmhrb_col_scan u_scan (
    .clk_i, .rst_ni, .start_i(scan_start), .row_i, .columns_i,
    .busy_o(scan_busy), .evt_o(evt)
  );

  kmhrb_collect #(
    .PRESS_LIMIT(PRESS_LIMIT), .REPORT_KEYS(REPORT_KEYS), .AUX_KEYS(AUX_KEYS)
  ) u_coll (
    .clk_i, .rst_ni, .evt_i(evt), .clear_i(clear),
    .mod_o(mod), .keys_o(keys), .aux_o(aux)
  );

  logic [16:0] d_raw;
  logic [55:0] key_rep;
  logic        k_send;
  always_comb begin
    d_raw = {2'b0, frame_count_i} - lsf_q;
    if (d_raw[16]) d_raw = {2'b0, kmhrb_pkg::FrameWrap} - lsf_q + {2'b0, frame_count_i};
    key_rep = {keys, mod};
    k_send = !kbusy_q && ((key_rep != last_key_q) ||
             ((idle_q != '0) && !delta_q[16] && (delta_q >= {4'b0, idle_q})));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; idle_q <= kmhrb_pkg::IdleReset;
      last_key_q <= '0; last_aux_q <= '0; lsf_q <= '0; ov_q <= 1'b0;
      ks_q <= 1'b0; as_q <= 1'b0; mb_q <= '0; kb_q <= '0; ab_q <= '0;
      delta_q <= '0; now_q <= '0; kbusy_q <= 1'b0; abusy_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr) idle_q <= pwdata[12:0];
      if (load) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (scan_start) state_q <= StRow;
          else if (acc && opcode_i) begin
            state_q <= StDelta;
            delta_q <= d_raw;
            now_q <= frame_count_i;
            kbusy_q <= key_port_busy_i; abusy_q <= aux_port_busy_i;
            if (!d_raw[16] && d_raw > {4'b0, kmhrb_pkg::DeltaClamp})
              lsf_q <= {2'b0, frame_count_i} - {4'b0, kmhrb_pkg::DeltaClamp};
          end
        end
        StRow: if (!scan_busy) state_q <= StIdle;
        StDelta: state_q <= StSend;
        StSend: begin
          if (load) begin
            state_q <= StIdle;
            ks_q <= k_send;
            mb_q <= k_send ? mod : 8'h00;
            kb_q <= k_send ? keys : 48'h0;
            if (k_send) begin
              last_key_q <= key_rep; lsf_q <= {2'b0, now_q};
            end
            as_q <= !abusy_q && (aux != last_aux_q);
            ab_q <= (!abusy_q && (aux != last_aux_q)) ? aux : 32'h0;
            if (!abusy_q) last_aux_q <= aux;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign key_send_o = ks_q;
  assign modifier_byte_o = mb_q;
  assign key_bytes_o = kb_q;
  assign aux_send_o = as_q;
  assign aux_bytes_o = ab_q;
  assign prdata = paddr ? 32'h0 : {19'b0, idle_q};
  assign pready = 1'b1;

  `KMHRB_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == StIdle)
  `KMHRB_ASSERT_NXT(a_send_out, clk_i, rst_ni, state_q == StSend, out_valid_o)
  `KMHRB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule
`default_nettype wire
